@@ design/iirl_pkg.sv @@
// ----------------------------------------------------------------------------
// iirl_pkg
// shared codes, field widths and controller/datapath interface structs
// ----------------------------------------------------------------------------
`default_nettype none

package iirl_pkg;

  // field widths of one transaction
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 6;
  localparam int DATA_W    = 32;
  localparam int LEN_W     = 6;
  localparam int STAT_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // operation codes
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the accepted command
    logic rd_idx;    // read the addressed entry
    logic rd_shift;  // read the neighbour of the shift pointer
    logic wr_shift;  // move the read word to the pointer, step the pointer
    logic wr_idx;    // write the new word at the addressed entry
    logic ptr_init;  // start the shift pointer
    logic cap_word;  // keep the word just read for the result
    logic finish;    // load the result register and commit the length
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             err;       // range or full error on the held command
    logic             more;      // shift not yet complete
    logic             out_free;  // result register can take a new result
  } ctl_stat_t;

endpackage

`default_nettype wire

@@ design/indexed_insert_remove_list.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// ordered list of up to DEPTH words with indexed read, insert, remove, replace
// ----------------------------------------------------------------------------
// One command transaction in gives one result transaction out. Commands are
// handled one at a time; the list lives in a single-port-write, registered-read
// memory, so an insert or remove moves the later words one at a time. Read
// and replace go through decode, entry read and finish; insert and remove
// run the shift loop before finish; an error goes from decode to finish.
// The input is ready again in the same cycle the result appears, and a new
// command is taken while the previous result still waits in the output
// register. An out-of-range index or an insert into a full list is reported
// in status, returns zero data and leaves the list untouched. Stored words
// need no clearing after reset: entries at or past the length are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_list #(
  parameter int DEPTH      = 32,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // command channel
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [iirl_pkg::IN_TDATA_W-1:0]      in_tdata,  // index[5:0], data_in[37:6]
  input  wire logic [iirl_pkg::CMD_W-1:0]           in_tuser,  // cmd[1:0]
  // result channel
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [iirl_pkg::OUT_TDATA_W-1:0]          out_tdata, // data_out[31:0], length[37:32],
                                                               // is_empty[38]
  output logic [iirl_pkg::STAT_W-1:0]               out_tuser  // status[1:0]
);

  iirl_pkg::ctl_cmd_t  ctl;
  iirl_pkg::ctl_stat_t stat;

  logic [iirl_pkg::IDX_W-1:0]  in_index;
  logic [iirl_pkg::DATA_W-1:0] in_data;
  logic [iirl_pkg::DATA_W-1:0] out_data;
  logic [iirl_pkg::LEN_W-1:0]  out_length;
  logic                        out_empty;

  // unpack the command transaction
  assign in_index = in_tdata[iirl_pkg::IDX_W-1:0];
  assign in_data  = in_tdata[iirl_pkg::IDX_W +: iirl_pkg::DATA_W];

  // sequencer: one command at a time
  iirl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .ctl      (ctl),
    .stat     (stat)
  );

  // store, length, shift pointer and result register
  iirl_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_tuser),
    .in_index   (in_index),
    .in_data    (in_data),
    .ctl        (ctl),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_data),
    .out_length (out_length),
    .out_empty  (out_empty),
    .out_status (out_tuser)
  );

  // pack the result transaction, padding to whole bytes
  assign out_tdata = {1'b0, out_empty, out_length, out_data};

endmodule

`default_nettype wire

@@ design/iirl_datapath.sv @@
// ----------------------------------------------------------------------------
// iirl_datapath
// word store, length counter, shift pointer and result register
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_datapath #(
  parameter int DEPTH      = 32,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [iirl_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [iirl_pkg::IDX_W-1:0]    in_index,
  input  wire logic [iirl_pkg::DATA_W-1:0]   in_data,
  input  wire iirl_pkg::ctl_cmd_t            ctl,
  output iirl_pkg::ctl_stat_t                stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [iirl_pkg::DATA_W-1:0]        out_data,
  output logic [iirl_pkg::LEN_W-1:0]         out_length,
  output logic                               out_empty,
  output logic [iirl_pkg::STAT_W-1:0]        out_status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > iirl_pkg::IDX_W) ? CW : iirl_pkg::IDX_W;

  logic [WORD_WIDTH-1:0]          mem [DEPTH];
  logic [WORD_WIDTH-1:0]          rdata_r;
  logic [WORD_WIDTH-1:0]          word_r;
  logic [WORD_WIDTH-1:0]          data_r;
  logic [iirl_pkg::CMD_W-1:0]     cmd_r;
  logic [iirl_pkg::IDX_W-1:0]     idx_r;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  ptr_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [iirl_pkg::DATA_W-1:0]    out_data_r;
  logic [iirl_pkg::LEN_W-1:0]     out_length_r;
  logic                           out_empty_r;
  logic [iirl_pkg::STAT_W-1:0]    out_status_r;

  logic                           is_insert, is_remove;
  logic                           range_err, full_err, err;
  logic [AW-1:0]                  idx_a, raddr, waddr;
  logic [WORD_WIDTH-1:0]          wdata;
  logic                           we;
  logic [iirl_pkg::STAT_W-1:0]    status;
  logic                           more;

  assign is_insert = (cmd_r == iirl_pkg::CMD_INSERT);
  assign is_remove = (cmd_r == iirl_pkg::CMD_REMOVE);

  // insert may address one past the end, the others may not
  assign range_err = is_insert ? (IW'(idx_r) >  IW'(count_r))
                               : (IW'(idx_r) >= IW'(count_r));
  assign full_err  = is_insert && (count_r == CW'(DEPTH));
  assign err       = range_err || full_err;
  assign status    = range_err ? iirl_pkg::ST_RANGE :
                     full_err  ? iirl_pkg::ST_FULL  : iirl_pkg::ST_OK;

  // only used once the index has passed the range check
  assign idx_a = AW'(idx_r);

  assign more = is_insert ? (ptr_r > idx_a)
                          : ((CW'(ptr_r) + CW'(1)) < count_r);

  assign raddr = ctl.rd_idx ? idx_a :
                 is_insert  ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
  assign we    = ctl.wr_idx || ctl.wr_shift;
  assign waddr = ctl.wr_idx ? idx_a  : ptr_r;
  assign wdata = ctl.wr_idx ? data_r : rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_idx || ctl.rd_shift) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.finish && !err) begin
      if (is_insert) begin
        count_nxt = count_r + CW'(1);
      end else if (is_remove) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  assign out_valid_nxt = ctl.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_index;
      data_r <= WORD_WIDTH'(in_data);
    end
    if (ctl.ptr_init) begin
      ptr_r <= is_insert ? AW'(count_r) : idx_a;
    end else if (ctl.wr_shift) begin
      ptr_r <= is_insert ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
    end
    if (ctl.cap_word) begin
      word_r <= rdata_r;
    end
    if (ctl.finish) begin
      out_data_r   <= (err || is_insert) ? '0 : iirl_pkg::DATA_W'(word_r);
      out_length_r <= iirl_pkg::LEN_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
      out_status_r <= status;
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.err      = err;
  assign stat.more     = more;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_length = out_length_r;
  assign out_empty  = out_empty_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

@@ design/iirl_ctrl.sv @@
// ----------------------------------------------------------------------------
// iirl_ctrl
// command sequencer: decode, entry access, shift loop and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output iirl_pkg::ctl_cmd_t       ctl,
  input  wire iirl_pkg::ctl_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDW,
    S_SH_CHK,
    S_SH_WR,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.err) begin
          state_nxt = S_FIN;
        end else if (stat.cmd == iirl_pkg::CMD_INSERT) begin
          ctl.ptr_init = 1'b1;
          state_nxt    = S_SH_CHK;
        end else begin
          ctl.rd_idx = 1'b1;
          state_nxt  = S_RDW;
        end
      end
      S_RDW: begin
        // read data for the addressed entry is now registered
        ctl.cap_word = 1'b1;
        if (stat.cmd == iirl_pkg::CMD_REPLACE) begin
          ctl.wr_idx = 1'b1;
        end
        if (stat.cmd == iirl_pkg::CMD_REMOVE) begin
          ctl.ptr_init = 1'b1;
          state_nxt    = S_SH_CHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SH_CHK: begin
        if (stat.more) begin
          ctl.rd_shift = 1'b1;
          state_nxt    = S_SH_WR;
        end else begin
          if (stat.cmd == iirl_pkg::CMD_INSERT) begin
            ctl.wr_idx = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_SH_WR: begin
        ctl.wr_shift = 1'b1;
        state_nxt    = S_SH_CHK;
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

@@ design/iirl_checker.sv @@
// ----------------------------------------------------------------------------
// iirl_checker
// port-level checks on the list, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tvalid,
  input wire logic                                 in_tready,
  input wire logic [iirl_pkg::IN_TDATA_W-1:0]      in_tdata,
  input wire logic [iirl_pkg::CMD_W-1:0]           in_tuser,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [iirl_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input wire logic [iirl_pkg::STAT_W-1:0]          out_tuser
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // commands are taken one at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is in progress");

  // empty flag agrees with the reported length
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[38] == (out_tdata[37:32] == 6'd0)))
    else $error("empty flag disagrees with length");

  // an error returns no data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != iirl_pkg::ST_OK) |-> (out_tdata[31:0] == 32'd0))
    else $error("error result carries data");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == iirl_pkg::ST_OK || out_tuser == iirl_pkg::ST_RANGE ||
                    out_tuser == iirl_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind indexed_insert_remove_list iirl_checker u_iirl_checker (.*);

`default_nettype wire

@@ bench/indexed_insert_remove_list_test.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_test
// self-checking bench for the indexed insert/remove list
// ----------------------------------------------------------------------------
// Commands go in through the in_ stream and results come back on the out_
// stream. A scoreboard keeps its own copy of the list and works out each
// expected result when a command transaction is taken. Every result
// transaction is compared field by field with the oldest expectation. A short
// directed sequence comes first, then random phases that grow, shrink and mix
// the list. Both sides idle and stall at random, except in one quiet phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module indexed_insert_remove_list_test;

  localparam int LIST_DEPTH  = 32;
  localparam int TAIL_CYCLES = 100;      // longer than the slowest command
  localparam int CYCLE_LIMIT = 800000;

  // one expected result transaction
  typedef struct {
    logic [iirl_pkg::DATA_W-1:0] word;
    logic [iirl_pkg::LEN_W-1:0]  length;
    logic                        is_empty;
    logic [iirl_pkg::STAT_W-1:0] status;
  } list_result_t;

  // keeps the expected list contents and the results still to come
  class list_scoreboard;
    logic [iirl_pkg::DATA_W-1:0] words [LIST_DEPTH];
    int unsigned                 fill;
    list_result_t                awaited [$];
    int                          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // apply one accepted command to the shadow list
    function void note_command(input logic [iirl_pkg::CMD_W-1:0] op,
                               input logic [iirl_pkg::IDX_W-1:0] pos,
                               input logic [iirl_pkg::DATA_W-1:0] word);
      list_result_t res;
      int unsigned  p;
      p          = 32'(pos);
      res.word   = '0;
      res.status = iirl_pkg::ST_OK;
      if (op == iirl_pkg::CMD_INSERT) begin
        if (p > fill) begin
          res.status = iirl_pkg::ST_RANGE;
        end else if (fill >= LIST_DEPTH) begin
          res.status = iirl_pkg::ST_FULL;
        end else begin
          for (int k = fill; k > p; k--) words[k] = words[k-1];
          words[p] = word;
          fill++;
        end
      end else if (p >= fill) begin
        res.status = iirl_pkg::ST_RANGE;
      end else begin
        res.word = words[p];
        if (op == iirl_pkg::CMD_REMOVE) begin
          for (int k = p; k + 1 < fill; k++) words[k] = words[k+1];
          fill--;
        end else if (op == iirl_pkg::CMD_REPLACE) begin
          words[p] = word;
        end
      end
      res.length   = fill[iirl_pkg::LEN_W-1:0];
      res.is_empty = (fill == 0);
      awaited.push_back(res);
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input logic [iirl_pkg::DATA_W-1:0] word,
                      input logic [iirl_pkg::LEN_W-1:0] length,
                      input logic is_empty, input logic [iirl_pkg::STAT_W-1:0] status);
      list_result_t want;
      if (awaited.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        want = awaited.pop_front();
        if (word !== want.word)
          report($sformatf("data_out %h, expected %h", word, want.word));
        if (length !== want.length)
          report($sformatf("length %0d, expected %0d", length, want.length));
        if (is_empty !== want.is_empty)
          report($sformatf("is_empty %b, expected %b", is_empty, want.is_empty));
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // clock, reset and block ports; the ones the bench drives are known from time zero
  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [iirl_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;  // index[5:0], data_in[37:6], zero pad
  logic [iirl_pkg::CMD_W-1:0]       in_tuser   = '0;  // cmd[1:0]
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [iirl_pkg::OUT_TDATA_W-1:0] out_tdata;  // data_out[31:0], length[37:32], is_empty[38]
  logic [iirl_pkg::STAT_W-1:0]      out_tuser;  // status[1:0]

  list_scoreboard sb = new();
  bit             no_idle = 1'b0;  // quiet phase: no gaps and no stalls
  int unsigned    cycles  = 0;

  indexed_insert_remove_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog on the whole run
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side: random ready pattern, every transaction checked
  initial begin : result_side
    int hold;
    bit rdy;
    hold = 0;
    rdy  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready)
        sb.check_result(out_tdata[31:0], out_tdata[37:32], out_tdata[38], out_tuser);
      if (!rst_n) begin
        rdy = 1'b0;
      end else if (no_idle) begin
        rdy = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rdy  = 1'b1;
          hold = $urandom_range(0, 19);
        end else if (r < 90) begin
          rdy  = 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          rdy  = 1'b0;
          hold = $urandom_range(7, 39);
        end
      end
      out_tready <= rdy;
    end
  end

  // one command transaction, noted in the scoreboard when taken
  task automatic send_cmd(input logic [iirl_pkg::CMD_W-1:0] op,
                          input logic [iirl_pkg::IDX_W-1:0] pos,
                          input logic [iirl_pkg::DATA_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, word, pos};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_command(op, pos, word);
  endtask

  // hold off the sender until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [iirl_pkg::DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // index mostly valid, sometimes just past the end, sometimes anywhere
  function automatic logic [iirl_pkg::IDX_W-1:0] pick_index(
      input logic [iirl_pkg::CMD_W-1:0] op);
    int unsigned top;
    int          r;
    top = (op == iirl_pkg::CMD_INSERT) ? sb.fill : sb.fill - 1;
    r   = $urandom_range(0, 99);
    if (r < 85 && (op == iirl_pkg::CMD_INSERT || sb.fill > 0)) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return top[iirl_pkg::IDX_W-1:0];
        default: return iirl_pkg::IDX_W'($urandom_range(0, top));
      endcase
    end
    if (r < 95)
      return iirl_pkg::IDX_W'((op == iirl_pkg::CMD_INSERT) ? sb.fill + 1 : sb.fill);
    return iirl_pkg::IDX_W'($urandom_range(0, 63));
  endfunction

  // random phase with given insert and remove weights (percent)
  task automatic run_phase(input int count, input int ins_pct, input int rem_pct);
    logic [iirl_pkg::CMD_W-1:0] op;
    int                         r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct)                 op = iirl_pkg::CMD_INSERT;
      else if (r < ins_pct + rem_pct)  op = iirl_pkg::CMD_REMOVE;
      else if (r[0])                   op = iirl_pkg::CMD_READ;
      else                             op = iirl_pkg::CMD_REPLACE;
      send_cmd(op, pick_index(op), pick_word());
    end
    drain();
  endtask

  initial begin : command_side
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each of these commands is out of range on the empty list
    send_cmd(iirl_pkg::CMD_READ,    6'd0,  32'h0000_0001);
    send_cmd(iirl_pkg::CMD_REMOVE,  6'd0,  32'h0000_0002);
    send_cmd(iirl_pkg::CMD_REPLACE, 6'd0,  32'h0000_0003);
    send_cmd(iirl_pkg::CMD_INSERT,  6'd1,  32'h0000_0004);
    send_cmd(iirl_pkg::CMD_INSERT,  6'd63, 32'hffff_ffff);
    // build a short list: append, front and middle inserts
    send_cmd(iirl_pkg::CMD_INSERT,  6'd0,  32'h0000_0000);
    send_cmd(iirl_pkg::CMD_INSERT,  6'd1,  32'hffff_ffff);
    send_cmd(iirl_pkg::CMD_INSERT,  6'd0,  32'ha5a5_a5a5);
    send_cmd(iirl_pkg::CMD_INSERT,  6'd1,  32'h5a5a_5a5a);
    send_cmd(iirl_pkg::CMD_READ,    6'd0,  32'h0);
    send_cmd(iirl_pkg::CMD_READ,    6'd3,  32'h0);
    send_cmd(iirl_pkg::CMD_READ,    6'd4,  32'h0);
    send_cmd(iirl_pkg::CMD_REPLACE, 6'd2,  32'h1234_5678);
    send_cmd(iirl_pkg::CMD_READ,    6'd2,  32'h0);
    send_cmd(iirl_pkg::CMD_REPLACE, 6'd63, 32'hdead_beef);
    send_cmd(iirl_pkg::CMD_INSERT,  6'd5,  32'h0bad_0bad);
    // remove from the middle, the tail and the head down to empty
    send_cmd(iirl_pkg::CMD_REMOVE,  6'd1,  32'h0);
    send_cmd(iirl_pkg::CMD_REMOVE,  6'd2,  32'h0);
    send_cmd(iirl_pkg::CMD_REMOVE,  6'd63, 32'h0);
    send_cmd(iirl_pkg::CMD_REMOVE,  6'd0,  32'h0);
    send_cmd(iirl_pkg::CMD_REMOVE,  6'd0,  32'h0);
    send_cmd(iirl_pkg::CMD_READ,    6'd0,  32'h0);
    drain();

    // random phases; growth runs into the full list, shrinking back to empty
    run_phase(150, 70, 15);
    run_phase(150, 15, 70);
    no_idle = 1'b1;
    run_phase(200, 40, 30);
    no_idle = 1'b0;
    run_phase(150, 75, 10);
    run_phase(300, 35, 35);
    run_phase(200, 10, 75);
    run_phase(150, 45, 30);

    // let any late or extra result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
